// ===== hdl/okrb_pkg.sv =====
// Shared types, constants and the control program of the offset-keyed random byte reader.
// Used by okrb_sequencer, okrb_datapath and offset_keyed_random_byte_reader.
package okrb_pkg;

  localparam int unsigned MaxReadBytes = 256;

  // Field widths
  localparam int unsigned OffsetW = 63;
  localparam int unsigned LengthW = 9;
  localparam int unsigned DataW   = 64;
  localparam int unsigned CountW  = 4;
  // Chunk index, one bit wider than the offset allows so the walk can pass 2^63
  localparam int unsigned ChunkW  = OffsetW - 2;

  // Stream widths, padded to whole bytes
  localparam int unsigned InTdataW  = ((OffsetW + LengthW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((DataW + CountW + 7) / 8) * 8;

  // Multiplier constant, split in 32-bit words from the low end
  localparam logic [31:0] KWord0 = 32'hb37916a5;
  localparam logic [31:0] KWord1 = 32'h2e714eb2;
  localparam logic [31:0] KWord2 = 32'hb500f16e;
  localparam logic [31:0] KWord3 = 32'h12e15e35;

  localparam int unsigned AccW  = 67;
  localparam int unsigned StepW = 4;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_IN,
    COND_EMIT,
    COND_GOTO
  } cond_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SHADD
  } acc_op_e;

  typedef struct packed {
    cond_e             cond;
    logic [StepW-1:0]  target;
    logic              a_sel;   // 0: address bits 31:0, 1: address bits 63:32
    logic [1:0]        k_sel;   // constant word index
    acc_op_e           acc_op;
    logic              cap_lo;  // capture low word of the result
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic len_zero;
    logic emit_fire;
    logic chunk_last;
  } stat_t;

  localparam logic [StepW-1:0] StepIdle  = 4'd0;
  localparam logic [StepW-1:0] StepChunk = 4'd1;

  function automatic logic [31:0] k_word(input logic [1:0] sel);
    logic [31:0] w;
    unique case (sel)
      2'd0: w = KWord0;
      2'd1: w = KWord1;
      2'd2: w = KWord2;
      2'd3: w = KWord3;
      default: w = KWord0;
    endcase
    return w;
  endfunction

  // Control program: column-wise multiply of the chunk address by the constant,
  // keeping only the columns that land in the upper 64 bits mod 2^128.
  function automatic ctrl_t ucode(input logic [StepW-1:0] pc);
    ctrl_t cw;
    cw = '{cond: COND_NEXT, target: StepIdle, a_sel: 1'b0, k_sel: 2'd0,
           acc_op: ACC_HOLD, cap_lo: 1'b0};
    unique case (pc)
      4'd0: cw.cond = COND_IN;
      4'd1: begin cw.a_sel = 1'b0; cw.k_sel = 2'd0; end
      4'd2: begin cw.a_sel = 1'b0; cw.k_sel = 2'd1; cw.acc_op = ACC_LOAD; end
      4'd3: begin cw.a_sel = 1'b1; cw.k_sel = 2'd0; cw.acc_op = ACC_SHADD; end
      4'd4: begin cw.a_sel = 1'b0; cw.k_sel = 2'd2; cw.acc_op = ACC_ADD; end
      4'd5: begin cw.a_sel = 1'b1; cw.k_sel = 2'd1; cw.acc_op = ACC_SHADD; end
      4'd6: begin cw.a_sel = 1'b0; cw.k_sel = 2'd3; cw.acc_op = ACC_ADD; end
      4'd7: begin
        cw.a_sel = 1'b1; cw.k_sel = 2'd2; cw.acc_op = ACC_SHADD; cw.cap_lo = 1'b1;
      end
      4'd8: cw.acc_op = ACC_ADD;
      4'd9: begin cw.cond = COND_EMIT; cw.target = StepChunk; end
      default: begin cw.cond = COND_GOTO; cw.target = StepIdle; end
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/okrb_sequencer.sv =====
// Step counter and control program lookup of the offset-keyed random byte reader.
// Depends on okrb_pkg.
module okrb_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  okrb_pkg::stat_t stat_i,
  output okrb_pkg::ctrl_t ctrl_o
);

  logic [okrb_pkg::StepW-1:0] pc_q, pc_d;
  okrb_pkg::ctrl_t            cw;

  assign cw     = okrb_pkg::ucode(pc_q);
  assign ctrl_o = cw;

  always_comb begin
    pc_d = pc_q;
    unique case (cw.cond)
      okrb_pkg::COND_NEXT: pc_d = pc_q + 1'b1;
      okrb_pkg::COND_IN: begin
        if (stat_i.in_fire && !stat_i.len_zero) pc_d = pc_q + 1'b1;
      end
      okrb_pkg::COND_EMIT: begin
        if (stat_i.emit_fire) pc_d = stat_i.chunk_last ? okrb_pkg::StepIdle : cw.target;
      end
      okrb_pkg::COND_GOTO: pc_d = cw.target;
      default: pc_d = okrb_pkg::StepIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= okrb_pkg::StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hdl/okrb_datapath.sv =====
// Datapath of the offset-keyed random byte reader: chunk walk, shared 32x32
// multiplier with accumulator, and byte lane alignment. Depends on okrb_pkg.
module okrb_datapath #(
  parameter int unsigned MAX_READ_BYTES = okrb_pkg::MaxReadBytes
) (
  input  logic                          clk_i,
  input  okrb_pkg::ctrl_t               ctrl_i,
  input  okrb_pkg::stat_t               stat_i,
  input  logic [okrb_pkg::OffsetW-1:0]  start_offset_i,
  input  logic [okrb_pkg::LengthW-1:0]  read_length_i,
  output logic [okrb_pkg::DataW-1:0]    data_bytes_o,
  output logic [okrb_pkg::CountW-1:0]   byte_count_o,
  output logic                          last_o
);

  localparam int unsigned RemW = $clog2(MAX_READ_BYTES + 1);

  logic [okrb_pkg::ChunkW-1:0] idx_q;
  logic [2:0]                  skip_q;
  logic                        first_q;
  logic [RemW-1:0]             rem_q;
  logic [63:0]                 prod_q;
  logic [okrb_pkg::AccW-1:0]   acc_q, acc_d;
  logic [31:0]                 wlo_q;

  logic [31:0]                 a_op, k_op;
  logic [63:0]                 prod_d;
  logic [okrb_pkg::LengthW-1:0] len_sat;
  logic [63:0]                 word, shifted;
  logic [2:0]                  skip_eff;
  logic [3:0]                  avail, cnt;
  logic                        last;

  assign a_op   = ctrl_i.a_sel ? idx_q[okrb_pkg::ChunkW-1:29] : {idx_q[28:0], 3'b000};
  assign k_op   = okrb_pkg::k_word(ctrl_i.k_sel);
  assign prod_d = a_op * k_op;

  always_comb begin
    unique case (ctrl_i.acc_op)
      okrb_pkg::ACC_HOLD:  acc_d = acc_q;
      okrb_pkg::ACC_LOAD:  acc_d = {3'b000, prod_q};
      okrb_pkg::ACC_ADD:   acc_d = acc_q + {3'b000, prod_q};
      okrb_pkg::ACC_SHADD: acc_d = (acc_q >> 32) + {3'b000, prod_q};
      default:             acc_d = acc_q;
    endcase
  end

  assign len_sat = (read_length_i > okrb_pkg::LengthW'(MAX_READ_BYTES))
                   ? okrb_pkg::LengthW'(MAX_READ_BYTES) : read_length_i;

  // Chunk geometry from the remaining byte count
  assign skip_eff = first_q ? skip_q : 3'd0;
  assign avail    = 4'd8 - {1'b0, skip_eff};
  assign last     = (rem_q <= RemW'(avail));
  assign cnt      = last ? rem_q[3:0] : avail;

  assign word    = {acc_q[31:0], wlo_q};
  assign shifted = word >> {skip_eff, 3'b000};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      data_bytes_o[i*8 +: 8] = (4'(i) < cnt) ? shifted[i*8 +: 8] : 8'h00;
    end
  end

  assign byte_count_o = cnt;
  assign last_o       = last;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (ctrl_i.cap_lo) wlo_q <= acc_q[31:0];
    if (stat_i.in_fire) begin
      idx_q   <= {1'b0, start_offset_i[okrb_pkg::OffsetW-1:3]};
      skip_q  <= start_offset_i[2:0];
      first_q <= 1'b1;
      rem_q   <= RemW'(len_sat);
    end else if (stat_i.emit_fire) begin
      // advance to the next chunk
      idx_q   <= idx_q + 1'b1;
      first_q <= 1'b0;
      rem_q   <= rem_q - RemW'(cnt);
    end
  end

endmodule

// ===== hdl/offset_keyed_random_byte_reader.sv =====
// Top level of the offset-keyed random byte reader: stream ports and output register.
// Depends on okrb_pkg, okrb_sequencer and okrb_datapath.
//
// Usage: a request item on the slave stream carries a byte start offset and a
// length; lengths above MAX_READ_BYTES are cut to it, and a zero length is taken
// and produces nothing. For each 8-byte aligned chunk the range touches, one
// result item leaves on the master stream with the requested bytes of the
// chunk's pseudo-random word packed from lane zero, their count, and tlast on
// the final chunk of the request.
// Sequence: the request is taken at the idle step; each chunk then runs eight
// steps of the single 32x32 multiplier and accumulator (seven partial products
// per chunk) and one emit step. A request touches at most 33 chunks.
// A finished chunk sits in the output register; the next chunk's multiply runs
// while it waits, and the emit step holds until the register is free. A new
// request is taken as soon as the last chunk is in the output register.
// Reset empties the output register and returns the sequencer to its idle step;
// there is no stored content to clear.
module offset_keyed_random_byte_reader #(
  parameter int unsigned MAX_READ_BYTES = okrb_pkg::MaxReadBytes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_offset [62:0], read_length [71:63]
  input  logic [okrb_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // data_bytes [63:0], byte_count [67:64], zero [71:68]
  output logic [okrb_pkg::OutTdataW-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast
);

  okrb_pkg::ctrl_t ctrl;
  okrb_pkg::stat_t stat;

  logic [okrb_pkg::OffsetW-1:0] start_offset;
  logic [okrb_pkg::LengthW-1:0] read_length;
  logic [okrb_pkg::DataW-1:0]   data_bytes;
  logic [okrb_pkg::CountW-1:0]  byte_count;
  logic                         chunk_last;
  logic                         out_free;

  logic                         out_valid_q;
  logic [okrb_pkg::DataW-1:0]   out_data_q;
  logic [okrb_pkg::CountW-1:0]  out_count_q;
  logic                         out_last_q;

  assign start_offset = s_axis_tdata[okrb_pkg::OffsetW-1:0];
  assign read_length  = s_axis_tdata[okrb_pkg::OffsetW +: okrb_pkg::LengthW];

  assign s_axis_tready = (ctrl.cond == okrb_pkg::COND_IN);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign stat.in_fire    = s_axis_tvalid && s_axis_tready;
  assign stat.len_zero   = (read_length == '0);
  assign stat.emit_fire  = (ctrl.cond == okrb_pkg::COND_EMIT) && out_free;
  assign stat.chunk_last = chunk_last;

  okrb_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  okrb_datapath #(
    .MAX_READ_BYTES (MAX_READ_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .stat_i         (stat),
    .start_offset_i (start_offset),
    .read_length_i  (read_length),
    .data_bytes_o   (data_bytes),
    .byte_count_o   (byte_count),
    .last_o         (chunk_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.emit_fire) begin
      out_data_q  <= data_bytes;
      out_count_q <= byte_count;
      out_last_q  <= chunk_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(okrb_pkg::OutTdataW - okrb_pkg::DataW - okrb_pkg::CountW){1'b0}},
                          out_count_q, out_data_q};
  assign m_axis_tlast  = out_last_q;

  // Request intake and chunk emission never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.in_fire && stat.emit_fire))
    else $error("request taken during chunk emission");

  // A nonzero request starts the chunk program
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.in_fire && !stat.len_zero |=> !s_axis_tready)
    else $error("sequencer idle after nonzero request");

  // Every emitted chunk carries one to eight bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.emit_fire |-> (byte_count != 4'd0) && (byte_count <= 4'd8))
    else $error("chunk byte count out of range");

endmodule

// ===== tb/offset_keyed_random_byte_reader_test.sv =====
// Self-checking bench for offset_keyed_random_byte_reader: random read requests in, chunk words out.
// Needs okrb_pkg and the reader RTL; predicts every chunk with a 128-bit multiply of its own.
module offset_keyed_random_byte_reader_test;

  localparam logic [127:0] MixKey      = 128'h12e15e35b500f16e_2e714eb2b37916a5;
  localparam int unsigned  ByteLimit   = 256;
  localparam int unsigned  RandomReads = 390;
  localparam int unsigned  StallLimit  = 3000;
  localparam int unsigned  DrainCycles = 40;

  typedef struct {
    logic [okrb_pkg::OffsetW-1:0] offset;
    logic [okrb_pkg::LengthW-1:0] length;
  } read_req_t;

  typedef struct {
    logic [okrb_pkg::DataW-1:0]  bytes;
    logic [okrb_pkg::CountW-1:0] count;
    logic                        last;
  } chunk_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [okrb_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [okrb_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  read_req_t   pending_reads[$];
  chunk_t      expected_chunks[$];
  int unsigned total_reads = 0;
  int unsigned zero_reads = 0;
  int unsigned clipped_reads = 0;
  int unsigned reads_sent = 0;
  int unsigned reads_accepted = 0;
  int unsigned chunks_checked = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] ready_pattern = 16'hffff;
  int unsigned pattern_age = 0;
  logic        steady;

  offset_keyed_random_byte_reader DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // No idling on either side through this window of requests
  assign steady = (reads_sent >= 150) && (reads_sent < 200);

  task automatic add_read(input logic [okrb_pkg::OffsetW-1:0] offset,
                          input logic [okrb_pkg::LengthW-1:0] length);
    read_req_t req;
    req.offset = offset;
    req.length = length;
    pending_reads.push_back(req);
    total_reads++;
    if (length == 0) zero_reads++;
    if (length > ByteLimit) clipped_reads++;
  endtask

  // Walk the aligned chunks of one read and queue the bytes each should deliver.
  task automatic queue_chunk_words(input logic [okrb_pkg::OffsetW-1:0] offset,
                                   input logic [okrb_pkg::LengthW-1:0] length);
    logic [63:0]  first;
    logic [63:0]  stop;
    logic [63:0]  base;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [127:0] product;
    logic [63:0]  word;
    int unsigned  span;
    chunk_t       chunk;
    span = (length > ByteLimit) ? ByteLimit : length;
    if (span == 0) return;
    first = {1'b0, offset};
    stop  = first + span;
    base  = first & ~64'd7;
    while (base < stop) begin
      lo = (first > base) ? first : base;
      hi = (stop < base + 8) ? stop : base + 8;
      product = {64'd0, base} * MixKey;
      word = product[127:64] >> (8 * (lo - base));
      if (hi - lo < 8) word &= (64'd1 << (8 * (hi - lo))) - 64'd1;
      chunk.bytes = word;
      chunk.count = okrb_pkg::CountW'(hi - lo);
      chunk.last  = (hi == stop);
      expected_chunks.push_back(chunk);
      base += 8;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_reads
    read_req_t req;
    logic      busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        queue_chunk_words(s_axis_tdata[okrb_pkg::OffsetW-1:0],
                          s_axis_tdata[okrb_pkg::OffsetW+okrb_pkg::LengthW-1:okrb_pkg::OffsetW]);
        reads_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left != 0 && !steady) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reads.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          req = pending_reads.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {req.length, req.offset};
          reads_sent++;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // end of burst: pick the next burst and the pause before it
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_chunks
    chunk_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        chunks_checked++;
        if (expected_chunks.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected chunk: data=%h count=%0d last=%b", $time,
                   m_axis_tdata[okrb_pkg::DataW-1:0],
                   m_axis_tdata[okrb_pkg::DataW+okrb_pkg::CountW-1:okrb_pkg::DataW],
                   m_axis_tlast);
        end else begin
          want = expected_chunks.pop_front();
          if (m_axis_tdata[okrb_pkg::DataW-1:0] !== want.bytes) begin
            mismatches++;
            $display("%0t: data_bytes expected %h actual %h", $time, want.bytes,
                     m_axis_tdata[okrb_pkg::DataW-1:0]);
          end
          if (m_axis_tdata[okrb_pkg::DataW+okrb_pkg::CountW-1:okrb_pkg::DataW] !== want.count)
          begin
            mismatches++;
            $display("%0t: byte_count expected %0d actual %0d", $time, want.count,
                     m_axis_tdata[okrb_pkg::DataW+okrb_pkg::CountW-1:okrb_pkg::DataW]);
          end
          if (m_axis_tlast !== want.last) begin
            mismatches++;
            $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
          end
          if (m_axis_tdata[okrb_pkg::OutTdataW-1:okrb_pkg::DataW+okrb_pkg::CountW] !== '0) begin
            mismatches++;
            $display("%0t: pad bits expected 0 actual %h", $time,
                     m_axis_tdata[okrb_pkg::OutTdataW-1:okrb_pkg::DataW+okrb_pkg::CountW]);
          end
        end
      end
      // Rotate the stall pattern; bits 0 and 15 stay set to bound each stall
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: ready_pattern = 16'hffff;
          1: ready_pattern = 16'($urandom) | 16'h8001;
          2: ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h8001;
          default: ready_pattern = 16'($urandom) | 16'($urandom) | 16'h8001;
        endcase
      end else begin
        pattern_age--;
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
      m_axis_tready <= steady | ready_pattern[0];
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == StallLimit) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, StallLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned                  counted;
    int unsigned                  pick;
    logic [okrb_pkg::OffsetW-1:0] offset;
    logic [okrb_pkg::LengthW-1:0] length;

    // Directed reads: chunk edges, full and partial chunks, empty reads, clipping, address extremes
    add_read(63'd0, 9'd1);
    add_read(63'd0, 9'd8);
    add_read(63'd3, 9'd2);
    add_read(63'd7, 9'd1);
    add_read(63'd4, 9'd4);
    add_read(63'd5, 9'd10);
    add_read(63'd1, 9'd256);
    add_read(63'd8, 9'd256);
    add_read(63'd0, 9'd0);
    add_read(63'd100, 9'd511);
    add_read(63'd13, 9'd257);
    add_read(63'd0, 9'd511);
    add_read(63'h0000_0000_ffff_fff8, 9'd16);
    add_read(63'h7fff_ffff_ffff_fef8, 9'd256);
    add_read(63'h7fff_ffff_ffff_fff8, 9'd8);
    add_read(63'h7fff_ffff_ffff_ffff, 9'd1);
    add_read(63'h7fff_ffff_ffff_ffff, 9'd511);
    add_read(63'h5555_5555_5555_5555, 9'h0aa);
    add_read(63'h2aaa_aaaa_aaaa_aaaa, 9'h155);
    add_read(63'h7fff_ffff_ffff_fff9, 9'd0);

    // Random reads: mostly short, some long, a few empty or clipped
    counted = 0;
    while (counted < RandomReads) begin
      case ($urandom_range(0, 3))
        0: offset = 63'h7fff_ffff_ffff_ffff - 63'($urandom_range(0, 600));
        1: offset = 63'($urandom_range(0, 4095));
        default: offset = 63'({$urandom, $urandom});
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 6) length = 9'd0;
      else if (pick < 14) length = 9'($urandom_range(257, 511));
      else if (pick < 34) length = 9'($urandom_range(1, 256));
      else length = 9'($urandom_range(1, 24));
      add_read(offset, length);
      counted++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (reads_accepted != total_reads || expected_chunks.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d read requests (%0d empty, %0d over the byte limit), %0d chunk items checked",
             total_reads, zero_reads, clipped_reads, chunks_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/okrb_pkg.sv
hdl/okrb_sequencer.sv
hdl/okrb_datapath.sv
hdl/offset_keyed_random_byte_reader.sv
tb/offset_keyed_random_byte_reader_test.sv
